// ===== src/bmp_stream_pixel_decoder_top_defines.svh =====
// assertion helpers for the bmp stream pixel decoder
`ifndef BMP_STREAM_PIXEL_DECODER_TOP_DEFINES_SVH
`define BMP_STREAM_PIXEL_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define BMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp decoder check failed");
// next-cycle implication
`define BMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp decoder check failed");
`else
`define BMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/bmp_dec_pkg.sv =====
package bmp_dec_pkg;

    localparam int MAX_DIM_DEF       = 2048;
    localparam int PIXEL_DATA_OFFSET = 54;

    localparam logic [7:0]  SIG_B        = 8'h42;
    localparam logic [7:0]  SIG_M        = 8'h4D;
    localparam logic [5:0]  OFF_WIDTH    = 6'h12;
    localparam logic [5:0]  OFF_HEIGHT   = 6'h16;
    localparam logic [5:0]  OFF_HEIGHT_E = 6'h1A;
    localparam logic [5:0]  OFF_DEPTH_LO = 6'h1C;
    localparam logic [5:0]  OFF_DEPTH_HI = 6'h1D;
    localparam logic [5:0]  OFF_LAST_HDR = 6'(PIXEL_DATA_OFFSET - 1);
    localparam logic [15:0] DEPTH_24     = 16'd24;
    localparam logic [15:0] DEPTH_32     = 16'd32;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_PIXEL,
        PH_PAD
    } t_phase;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_NOT_BMP,
        ST_BAD_DEPTH,
        ST_TOO_LARGE
    } t_status;

    typedef enum logic {
        REG_ORIGIN_X,
        REG_ORIGIN_Y
    } t_reg_idx;

    typedef struct packed {
        logic [10:0] origin_x;
        logic [10:0] origin_y;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] color;
        logic        last_pixel;
    } t_result;

    function automatic logic [31:0] set_byte32(logic [31:0] w, logic [1:0] k, logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[{k, 3'b000} +: 8] = b;
        return r;
    endfunction

    function automatic logic [31:0] magnitude(logic [31:0] w);
        return w[31] ? (32'd0 - w) : w;
    endfunction

endpackage

// ===== src/bmp_dec_apb.sv =====
module bmp_dec_apb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready,
    output bmp_dec_pkg::t_cfg   o_cfg
);
    import bmp_dec_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx    = t_reg_idx'(i_paddr[2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ORIGIN_X: r_cfg.origin_x <= i_pwdata[10:0];
                REG_ORIGIN_Y: r_cfg.origin_y <= i_pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ORIGIN_X: o_prdata = {21'd0, r_cfg.origin_x};
            REG_ORIGIN_Y: o_prdata = {21'd0, r_cfg.origin_y};
            default:      o_prdata = '0;
        endcase
    end

endmodule

// ===== src/bmp_dec_core.sv =====
module bmp_dec_core #(
    parameter int MAX_DIM = bmp_dec_pkg::MAX_DIM_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_in_byte,
    input  logic                  i_in_sof,
    input  bmp_dec_pkg::t_cfg     i_cfg,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output bmp_dec_pkg::t_result  o_res
);
    import bmp_dec_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // input register
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_sof;

    // parser state
    t_phase            r_phase, n_phase;
    logic [5:0]        r_offset, n_offset;
    logic [31:0]       r_width, n_width;
    logic [31:0]       r_height, n_height;
    logic [15:0]       r_depth, n_depth;
    logic [DIM_W-1:0]  r_aw, n_aw;
    logic [DIM_W-1:0]  r_ah, n_ah;
    logic              r_is32, n_is32;
    logic [DIM_W-1:0]  r_col, n_col;
    logic [DIM_W-1:0]  r_row, n_row;
    logic [1:0]        r_bip, n_bip;
    logic [23:0]       r_color, n_color;
    logic [1:0]        r_pad, n_pad;

    // effective state after a possible restart
    logic              w_adv;
    t_phase            w_phase;
    logic [5:0]        w_off;
    logic [31:0]       w_width, w_height;
    logic [15:0]       w_depth, w_depth_new;
    logic [31:0]       w_mag_w, w_mag_h;

    logic              w_sig_err, w_depth_err, w_size_err, w_hdr_err, w_hdr_end, w_empty;
    logic              w_last_byte, w_row_wrap, w_last;
    logic [DIM_W:0]    w_col_inc, w_row_inc;
    logic [1:0]        w_row_pad, w_pad_dec;
    logic [23:0]       w_color_upd;
    logic [11:0]       w_ox, w_oy, w_aw12, w_ah12, w_col12, w_row12, w_px, w_py;

    assign w_adv      = r_in_valid & i_res_ready;
    assign o_in_ready = ~r_in_valid | w_adv;

    assign w_phase  = r_in_sof ? PH_HEADER : r_phase;
    assign w_off    = r_in_sof ? 6'd0 : r_offset;
    assign w_width  = r_in_sof ? 32'd0 : r_width;
    assign w_height = r_in_sof ? 32'd0 : r_height;
    assign w_depth  = r_in_sof ? 16'd0 : r_depth;

    always_comb begin
        w_depth_new = w_depth;
        if (w_off == OFF_DEPTH_LO) w_depth_new = {w_depth[15:8], r_in_byte};
        if (w_off == OFF_DEPTH_HI) w_depth_new = {r_in_byte, w_depth[7:0]};
    end

    // width and height are complete by the depth bytes
    assign w_mag_w     = magnitude(w_width);
    assign w_mag_h     = magnitude(w_height);
    assign w_sig_err   = ((w_off == 6'd0) && (r_in_byte != SIG_B)) ||
                         ((w_off == 6'd1) && (r_in_byte != SIG_M));
    assign w_depth_err = (w_depth_new != DEPTH_24) && (w_depth_new != DEPTH_32);
    assign w_size_err  = (w_mag_w > 32'(MAX_DIM)) || (w_mag_h > 32'(MAX_DIM));
    assign w_hdr_err   = w_sig_err || ((w_off == OFF_DEPTH_HI) && (w_depth_err || w_size_err));
    assign w_hdr_end   = (w_off >= OFF_LAST_HDR);
    assign w_empty     = (r_aw == '0) || (r_ah == '0);

    // pixel datapath
    assign w_last_byte = r_is32 ? (r_bip == 2'd3) : (r_bip == 2'd2);
    assign w_col_inc   = {1'b0, r_col} + {{DIM_W{1'b0}}, 1'b1};
    assign w_row_inc   = {1'b0, r_row} + {{DIM_W{1'b0}}, 1'b1};
    assign w_row_wrap  = (w_col_inc >= {1'b0, r_aw});
    assign w_last      = w_row_wrap && (w_row_inc >= {1'b0, r_ah});
    assign w_row_pad   = r_is32 ? 2'd0 : 2'(r_aw);
    assign w_pad_dec   = r_pad - 2'd1;

    always_comb begin
        w_color_upd = r_color;
        case (r_bip)
            2'd0:    w_color_upd[7:0]   = r_in_byte;
            2'd1:    w_color_upd[15:8]  = r_in_byte;
            2'd2:    w_color_upd[23:16] = r_in_byte;
            default: w_color_upd        = r_color;
        endcase
    end

    assign w_ox    = {1'b0, i_cfg.origin_x};
    assign w_oy    = {1'b0, i_cfg.origin_y};
    assign w_aw12  = 12'(r_aw);
    assign w_ah12  = 12'(r_ah);
    assign w_col12 = 12'(r_col);
    assign w_row12 = 12'(r_row);
    // negative width mirrors, positive height is stored bottom-up
    assign w_px = r_width[31]  ? (w_ox + w_aw12 - 12'd1 - w_col12) : (w_ox + w_col12);
    assign w_py = r_height[31] ? (w_oy + w_row12) : (w_oy + w_ah12 - 12'd1 - w_row12);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_adv) begin
            unique case (w_phase)
                PH_WAIT: n_phase = PH_WAIT;
                PH_HEADER: begin
                    if (w_hdr_err)      n_phase = PH_WAIT;
                    else if (w_hdr_end) n_phase = w_empty ? PH_WAIT : PH_PIXEL;
                    else                n_phase = PH_HEADER;
                end
                PH_PIXEL: begin
                    if (w_last_byte && w_last)
                        n_phase = PH_WAIT;
                    else if (w_last_byte && w_row_wrap && (w_row_pad != 2'd0))
                        n_phase = PH_PAD;
                    else
                        n_phase = PH_PIXEL;
                end
                PH_PAD: n_phase = (w_pad_dec == 2'd0) ? PH_PIXEL : PH_PAD;
                default: n_phase = PH_WAIT;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_offset    = r_offset;
        n_width     = r_width;
        n_height    = r_height;
        n_depth     = r_depth;
        n_aw        = r_aw;
        n_ah        = r_ah;
        n_is32      = r_is32;
        n_col       = r_col;
        n_row       = r_row;
        n_bip       = r_bip;
        n_color     = r_color;
        n_pad       = r_pad;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (w_adv) begin
            if (r_in_sof) begin
                n_offset = '0;
                n_width  = '0;
                n_height = '0;
                n_depth  = '0;
                n_col    = '0;
                n_row    = '0;
                n_bip    = '0;
                n_color  = '0;
                n_pad    = '0;
            end
            unique case (w_phase)
                PH_WAIT: ;
                PH_HEADER: begin
                    if (w_sig_err) begin
                        o_res_valid = 1'b1;
                        o_res.status = ST_NOT_BMP;
                    end else begin
                        if ((w_off >= OFF_WIDTH) && (w_off < OFF_HEIGHT))
                            n_width = set_byte32(w_width, 2'(w_off - OFF_WIDTH), r_in_byte);
                        if ((w_off >= OFF_HEIGHT) && (w_off < OFF_HEIGHT_E))
                            n_height = set_byte32(w_height, 2'(w_off - OFF_HEIGHT), r_in_byte);
                        n_depth = w_depth_new;
                        if (w_off == OFF_DEPTH_HI) begin
                            n_aw   = w_mag_w[DIM_W-1:0];
                            n_ah   = w_mag_h[DIM_W-1:0];
                            n_is32 = (w_depth_new == DEPTH_32);
                            if (w_depth_err) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_BAD_DEPTH;
                            end else if (w_size_err) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_TOO_LARGE;
                            end
                        end
                        if (w_hdr_end) begin
                            n_col   = '0;
                            n_row   = '0;
                            n_bip   = '0;
                            n_color = '0;
                        end else begin
                            n_offset = w_off + 6'd1;
                        end
                    end
                end
                PH_PIXEL: begin
                    n_color = w_color_upd;
                    if (!w_last_byte) begin
                        n_bip = r_bip + 2'd1;
                    end else begin
                        n_bip = '0;
                        o_res_valid      = 1'b1;
                        o_res.status     = ST_PIXEL;
                        o_res.pixel_x    = w_px;
                        o_res.pixel_y    = w_py;
                        o_res.color      = {(r_is32 ? r_in_byte : 8'h00), w_color_upd};
                        o_res.last_pixel = w_last;
                        if (w_row_wrap) begin
                            n_col = '0;
                            if (!w_last) begin
                                n_row = w_row_inc[DIM_W-1:0];
                                if (w_row_pad != 2'd0) n_pad = w_row_pad;
                            end
                        end else begin
                            n_col = w_col_inc[DIM_W-1:0];
                        end
                    end
                end
                PH_PAD: n_pad = w_pad_dec;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_WAIT;
            r_offset   <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_bip      <= '0;
            r_pad      <= '0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_col    <= n_col;
            r_row    <= n_row;
            r_bip    <= n_bip;
            r_pad    <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_sof  <= i_in_sof;
        end
        r_width  <= n_width;
        r_height <= n_height;
        r_depth  <= n_depth;
        r_aw     <= n_aw;
        r_ah     <= n_ah;
        r_is32   <= n_is32;
        r_color  <= n_color;
    end

endmodule

// ===== src/bmp_dec_obuf.sv =====
module bmp_dec_obuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  bmp_dec_pkg::t_result  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output bmp_dec_pkg::t_result  o_data
);
    import bmp_dec_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_push, w_free;

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_push  = i_valid & ~r_skid_valid;
    assign w_free  = ~r_out_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            r_out_valid  <= r_skid_valid | w_push;
            r_skid_valid <= 1'b0;
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // a word parks in the skid stage while the output is stalled
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_valid)  r_out <= r_skid;
            else if (w_push)   r_out <= i_data;
        end else if (w_push) begin
            r_skid <= i_data;
        end
    end

endmodule

// ===== src/bmp_stream_pixel_decoder_top.sv =====
// bmp stream pixel decoder
// s_axis carries the file one byte per word: tdata is the byte, tuser marks
// offset zero and restarts the parser at any time.
// m_axis carries one word per pixel or per error: tuser is the status
// (pixel, not bmp, unsupported depth, dimension too large), tlast marks the
// last pixel of the image, tdata holds the pixel position and 0xAARRGGBB
// color. error words carry zero position and color.
// origin_x at address 0x0 and origin_y at 0x4 are written over apb; the user
// must write them only while the stream is idle, the block does not enforce it;
// pready is always high. throughput is one byte per cycle while the output
// stage has room: the byte register feeds a single pass of header and pixel
// counter logic that writes the result register.
// a two-word output stage keeps s_axis_tready high while one result waits on
// m_axis_tready; it drops only when both words are held.
// reset (synchronous, active low) clears both channels and puts the parser
// into the state that ignores bytes until a start byte arrives.
`include "bmp_stream_pixel_decoder_top_defines.svh"
module bmp_stream_pixel_decoder_top #(
    parameter int MAX_DIM = bmp_dec_pkg::MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // start_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pixel_x[11:0], pixel_y[23:12], color[55:24]
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmp_dec_pkg::*;

    t_cfg    w_cfg;
    t_result w_res, w_out;
    logic    w_res_valid, w_res_ready;

    bmp_dec_apb u_apb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    bmp_dec_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_byte   (s_axis_tdata),
        .i_in_sof    (s_axis_tuser),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    bmp_dec_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .o_ready (w_res_ready),
        .i_data  (w_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.color, w_out.pixel_y, w_out.pixel_x};
    assign m_axis_tuser = w_out.status;
    assign m_axis_tlast = w_out.last_pixel;

    // error words never carry a position, color or last mark
    `BMP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_PIXEL), (m_axis_tdata == 56'd0) && !m_axis_tlast)
    // input stalls only when the output stage is backed up
    `BMP_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !w_res_ready)
    // an apb write to origin_x lands in the register
    `BMP_ASSERT_NXT(a_cfg_wr, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[2], w_cfg.origin_x == $past(pwdata[10:0]))

endmodule

// ===== verif/tb_bmp_stream_pixel_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_bmp_stream_pixel_decoder_top;
    import bmp_dec_pkg::*;

    typedef struct packed {
        bit          hdr;      // 0: loose bytes with no start marker
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        logic [5:0]  hlen;
        int          body;     // bytes after the header, -1 for the whole image
        bit          pinned;
        t_status     st;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // decoder state mirror
    logic [10:0] org_x;
    logic [10:0] org_y;
    logic [5:0]  hdr_pos;
    t_phase      prs_phase;
    logic [31:0] wd_word;
    logic [31:0] ht_word;
    logic [15:0] bpp_word;
    logic [11:0] col_cnt;
    logic [11:0] row_cnt;
    logic [1:0]  pix_byte;
    logic [23:0] rgb_acc;
    logic [1:0]  pad_left;

    t_result     pending_words [$];
    t_result     head_word;
    int          err_count = 0;
    int          file_bytes;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          pinned_on;
    t_status     pinned_status;

    t_stim_row dir_rows [0:19] = '{
        '{1'b0, 8'h00, 8'h00, 32'd0, 32'd0, 16'd0, 6'd0, 6, 1'b0, ST_PIXEL},
        '{1'b1, 8'h00, SIG_M, 32'd4, 32'd4, DEPTH_24, 6'd54, 3, 1'b1, ST_NOT_BMP},
        '{1'b1, SIG_B, 8'h00, 32'd4, 32'd4, DEPTH_24, 6'd54, 3, 1'b1, ST_NOT_BMP},
        '{1'b1, SIG_B, SIG_M, 32'd4, 32'd4, 16'd16, 6'd54, 3, 1'b1, ST_BAD_DEPTH},
        '{1'b1, SIG_B, SIG_M, 32'd4, 32'd4, 16'h0118, 6'd54, 0, 1'b1, ST_BAD_DEPTH},
        '{1'b1, SIG_B, SIG_M, 32'd5000, 32'd1, 16'd8, 6'd54, 0, 1'b1, ST_BAD_DEPTH},
        '{1'b1, SIG_B, SIG_M, 32'd2049, 32'd1, DEPTH_24, 6'd54, 2, 1'b1, ST_TOO_LARGE},
        '{1'b1, SIG_B, SIG_M, 32'd1, -32'd2049, DEPTH_32, 6'd54, 2, 1'b1, ST_TOO_LARGE},
        '{1'b1, SIG_B, SIG_M, 32'h8000_0000, 32'd1, DEPTH_24, 6'd54, 0, 1'b1, ST_TOO_LARGE},
        '{1'b1, SIG_B, SIG_M, 32'd0, 32'd3, DEPTH_24, 6'd54, 8, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd1, 32'd1, DEPTH_32, 6'd54, -1, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd3, 32'd2, DEPTH_24, 6'd54, -1, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, -32'd2, -32'd2, DEPTH_24, 6'd54, -1, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, -32'd2048, 32'd2048, DEPTH_32, 6'd54, 12, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd2048, -32'd2048, DEPTH_24, 6'd54, 9, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd5, 32'd1, DEPTH_24, 6'd54, 7, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd2, 32'd2, DEPTH_24, 6'd20, 0, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd1, 32'd4, DEPTH_24, 6'd54, -1, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, 32'd4, -32'd3, DEPTH_32, 6'd54, -1, 1'b0, ST_PIXEL},
        '{1'b1, SIG_B, SIG_M, -32'd3, 32'd1, DEPTH_24, 6'd54, -1, 1'b0, ST_PIXEL}
    };

    bmp_stream_pixel_decoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** bmp_stream_pixel_decoder_top: FAILED **");
        $finish;
    end

    function automatic logic [31:0] abs_dim(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] rand_dim(input int unsigned lo, input int unsigned hi);
        logic [31:0] v;
        v = $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic parser_clear();
        hdr_pos   = '0;
        prs_phase = PH_WAIT;
        wd_word   = '0;
        ht_word   = '0;
        bpp_word  = '0;
        col_cnt   = '0;
        row_cnt   = '0;
        pix_byte  = '0;
        rgb_acc   = '0;
        pad_left  = '0;
    endtask

    task automatic decode_byte(input logic [7:0] b, input bit sof,
                               output bit got, output t_result r);
        int unsigned off;
        int unsigned nb;
        logic [31:0] aw;
        logic [31:0] ah;
        logic [31:0] px;
        logic [31:0] py;
        logic [1:0]  pad;
        bit          bad;
        t_status     code;
        got  = 1'b0;
        r    = '0;
        bad  = 1'b0;
        code = ST_PIXEL;
        if (sof) begin
            parser_clear();
            prs_phase = PH_HEADER;
        end
        aw = abs_dim(wd_word);
        ah = abs_dim(ht_word);
        nb = (bpp_word == DEPTH_32) ? 4 : 3;
        case (prs_phase)
            PH_HEADER: begin
                off = hdr_pos;
                if ((off == 0 && b != SIG_B) || (off == 1 && b != SIG_M)) begin
                    bad  = 1'b1;
                    code = ST_NOT_BMP;
                end else begin
                    if (off >= OFF_WIDTH && off < OFF_HEIGHT)
                        wd_word[8*(off - OFF_WIDTH) +: 8] = b;
                    if (off >= OFF_HEIGHT && off < OFF_HEIGHT_E)
                        ht_word[8*(off - OFF_HEIGHT) +: 8] = b;
                    if (off == OFF_DEPTH_LO)
                        bpp_word[7:0] = b;
                    if (off == OFF_DEPTH_HI) begin
                        bpp_word[15:8] = b;
                        // depth is judged before the size
                        if (bpp_word != DEPTH_24 && bpp_word != DEPTH_32) begin
                            bad  = 1'b1;
                            code = ST_BAD_DEPTH;
                        end else if (abs_dim(wd_word) > MAX_DIM_DEF ||
                                     abs_dim(ht_word) > MAX_DIM_DEF) begin
                            bad  = 1'b1;
                            code = ST_TOO_LARGE;
                        end
                    end
                    if (!bad) begin
                        if (off + 1 >= PIXEL_DATA_OFFSET) begin
                            if (abs_dim(wd_word) == 0 || abs_dim(ht_word) == 0)
                                prs_phase = PH_WAIT;
                            else
                                prs_phase = PH_PIXEL;
                            col_cnt  = '0;
                            row_cnt  = '0;
                            pix_byte = '0;
                            rgb_acc  = '0;
                        end else begin
                            hdr_pos = 6'(off + 1);
                        end
                    end
                end
                if (bad) begin
                    prs_phase = PH_WAIT;
                    got       = 1'b1;
                    r.status  = code;
                end
            end
            PH_PAD: begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 0)
                    prs_phase = PH_PIXEL;
            end
            PH_PIXEL: begin
                if (pix_byte < 3)
                    rgb_acc[8*pix_byte +: 8] = b;
                if (pix_byte + 1 < nb) begin
                    pix_byte = pix_byte + 2'd1;
                end else begin
                    pix_byte = '0;
                    r.color  = {(nb == 4) ? b : 8'h00, rgb_acc};
                    // negative width mirrors, positive height runs bottom-up
                    px = wd_word[31] ? org_x + aw - 1 - col_cnt : org_x + col_cnt;
                    py = ht_word[31] ? org_y + row_cnt : org_y + ah - 1 - row_cnt;
                    r.pixel_x = px[11:0];
                    r.pixel_y = py[11:0];
                    col_cnt   = col_cnt + 12'd1;
                    if (col_cnt >= aw) begin
                        col_cnt = '0;
                        if (row_cnt + 1 >= ah) begin
                            r.last_pixel = 1'b1;
                            prs_phase    = PH_WAIT;
                        end else begin
                            pad     = (nb == 3) ? aw[1:0] : 2'd0;
                            row_cnt = row_cnt + 12'd1;
                            if (pad != 0) begin
                                pad_left  = pad;
                                prs_phase = PH_PAD;
                            end
                        end
                    end
                    r.status = ST_PIXEL;
                    got      = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input bit sof);
        bit      got;
        t_result r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= sof;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b, sof, got, r);
        if (got) begin
            if (pinned_on) begin
                r        = '0;
                r.status = pinned_status;
            end
            pending_words.push_back(r);
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_file(input logic [7:0] s0, input logic [7:0] s1,
                             input logic [31:0] w, input logic [31:0] h,
                             input logic [15:0] bpp, input int hlen, input int body);
        int unsigned aw;
        int unsigned ah;
        int unsigned nb;
        int unsigned total;
        logic [7:0]  b;
        for (int off = 0; off < hlen; off++) begin
            b = 8'($urandom);
            if (off == 0)
                b = s0;
            else if (off == 1)
                b = s1;
            else if (off >= OFF_WIDTH && off < OFF_HEIGHT)
                b = w[8*(off - OFF_WIDTH) +: 8];
            else if (off >= OFF_HEIGHT && off < OFF_HEIGHT_E)
                b = h[8*(off - OFF_HEIGHT) +: 8];
            else if (off == OFF_DEPTH_LO)
                b = bpp[7:0];
            else if (off == OFF_DEPTH_HI)
                b = bpp[15:8];
            push_byte(b, off == 0);
            file_bytes++;
        end
        if (body < 0) begin
            aw = abs_dim(w);
            ah = abs_dim(h);
            nb = (bpp == DEPTH_32) ? 4 : 3;
            // rows padded to 4 bytes, then a few stray trailing bytes
            total = ah * (aw * nb + ((nb == 3) ? aw % 4 : 0)) + $urandom_range(0, 3);
        end else begin
            total = body;
        end
        repeat (total) begin
            push_byte(8'($urandom), 1'b0);
            file_bytes++;
        end
    endtask

    task automatic rand_file();
        int unsigned pick;
        logic [7:0]  s0;
        logic [7:0]  s1;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] bpp;
        int          hlen;
        int          body;
        pick = $urandom_range(0, 99);
        s0   = SIG_B;
        s1   = SIG_M;
        w    = rand_dim(1, 6);
        h    = rand_dim(1, 5);
        bpp  = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
        hlen = PIXEL_DATA_OFFSET;
        body = -1;
        if (pick < 60) begin
            // well-formed small image
        end else if (pick < 68) begin
            body = $urandom_range(0, 30);
        end else if (pick < 72) begin
            // huge image abandoned after a few pixels
            w    = rand_dim($urandom_range(0, 1) ? 2048 : 1700, 2048);
            h    = rand_dim($urandom_range(0, 1) ? 2048 : 1700, 2048);
            body = $urandom_range(0, 24);
        end else if (pick < 76) begin
            hlen = $urandom_range(1, 53);
            body = 0;
        end else if (pick < 80) begin
            if ($urandom_range(0, 1))
                s0 = 8'($urandom);
            else
                s1 = 8'($urandom);
            body = 4;
        end else if (pick < 85) begin
            bpp  = 16'($urandom);
            body = 4;
        end else if (pick < 90) begin
            if ($urandom_range(0, 1))
                w = $urandom_range(0, 1) ? 32'($urandom) : rand_dim(2049, 2100);
            else
                h = $urandom_range(0, 1) ? 32'($urandom) : rand_dim(2049, 2100);
            body = 4;
        end else if (pick < 94) begin
            if ($urandom_range(0, 1))
                w = '0;
            else
                h = '0;
        end
        if (pick < 94) begin
            send_file(s0, s1, w, h, bpp, hlen, body);
        end else begin
            repeat ($urandom_range(1, 12))
                push_byte(8'($urandom), $urandom_range(0, 15) == 0);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ORIGIN_X)
            org_x = val[10:0];
        else
            org_y = val[10:0];
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("output word with nothing pending: status %0d", m_axis_tuser);
                err_count++;
            end else begin
                head_word = pending_words.pop_front();
                if (m_axis_tuser !== head_word.status) begin
                    $error("status: expected %0d, got %0d", head_word.status, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[11:0] !== head_word.pixel_x) begin
                    $error("pixel_x: expected %0d, got %0d",
                           head_word.pixel_x, m_axis_tdata[11:0]);
                    err_count++;
                end
                if (m_axis_tdata[23:12] !== head_word.pixel_y) begin
                    $error("pixel_y: expected %0d, got %0d",
                           head_word.pixel_y, m_axis_tdata[23:12]);
                    err_count++;
                end
                if (m_axis_tdata[55:24] !== head_word.color) begin
                    $error("color: expected %08h, got %08h",
                           head_word.color, m_axis_tdata[55:24]);
                    err_count++;
                end
                if (m_axis_tlast !== head_word.last_pixel) begin
                    $error("last_pixel: expected %0d, got %0d",
                           head_word.last_pixel, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin
        logic [31:0] xv;
        logic [31:0] yv;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        pinned_on     = 1'b0;
        pinned_status = ST_PIXEL;
        file_bytes    = 0;
        org_x         = '0;
        org_y         = '0;
        parser_clear();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            pinned_on     = dir_rows[i].pinned;
            pinned_status = dir_rows[i].st;
            if (dir_rows[i].hdr)
                send_file(dir_rows[i].s0, dir_rows[i].s1, dir_rows[i].w, dir_rows[i].h,
                          dir_rows[i].bpp, dir_rows[i].hlen, dir_rows[i].body);
            else
                repeat (dir_rows[i].body) push_byte(8'($urandom), 1'b0);
        end
        pinned_on = 1'b0;
        drain();

        for (int p = 0; p < 4; p++) begin
            xv = (p == 0 || p == 3) ? 32'd2047 : (p == 1 || p == 4) ? 32'd0 : $urandom;
            yv = (p == 0 || p == 4) ? 32'd2047 : (p == 1 || p == 3) ? 32'd0 : $urandom;
            cfg_write(REG_ORIGIN_X, xv);
            cfg_write(REG_ORIGIN_Y, yv);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            // far corner with the origin at its maximum still fits the 12-bit position
            if (p == 0)
                send_file(SIG_B, SIG_M, -32'd2048, 32'd2048, DEPTH_32,
                          PIXEL_DATA_OFFSET, 12);
            file_bytes = 0;
            while (file_bytes < 40) begin
                rand_file();
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            drain();
        end

        if (err_count == 0)
            $display("** bmp_stream_pixel_decoder_top: PASSED **");
        else
            $display("** bmp_stream_pixel_decoder_top: FAILED **");
        $finish;
    end

endmodule
